// ===== sv/rfps_pkg.sv =====
// Shared types and constants for the rarest-first piece selector.
package rfps_pkg;

    localparam int INDEX_BITS  = 16;
    localparam int BLOCK_BITS  = 11;
    localparam int HOLD_BITS   = 8;
    localparam int SCORE_BITS  = 17;
    localparam int QUO_BITS    = 10;
    localparam int DVD_BITS    = 2 * QUO_BITS;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
    localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);
    localparam int IN_DATA_BITS  = 48;
    localparam int OUT_DATA_BITS = 16;
    localparam int OUT_USER_BITS = 2;

    localparam logic [BLOCK_BITS-1:0] MAX_BLOCKS  = 11'd1024;
    localparam logic [HOLD_BITS-1:0]  MAX_HOLDERS = 8'd255;
    localparam logic [QUO_BITS-1:0]   PER_MILLE   = 10'd1000;
    localparam logic [6:0]            SCORE_SCALE = 7'd100;
    localparam logic [SCORE_BITS-1:0] NO_HOLDER_RARITY = 17'd10000;

    typedef struct packed {
        logic [INDEX_BITS-1:0] index;
        logic                  partial;
        logic                  pending;
        logic [BLOCK_BITS-1:0] received;
        logic [BLOCK_BITS-1:0] total;
        logic [HOLD_BITS-1:0]  holders;
        logic                  last;
    } item_t;

endpackage

// ===== sv/rarest_first_piece_selector_unit.sv =====
// Back end: a record that is done or has no progress is popped and then updated;
// a partial record runs pop, two 10-step divisions in the shared divider, score, update.
// The back end takes a new record from the queue only once it has finished the last one.
// A four-entry queue lets the front end keep taking records while the divider runs.
// The result is registered and appears in the cycle after the last record's update.
// Reset (rst_n low, asynchronous) empties the queue and clears all scan state.
module rarest_first_piece_selector_unit (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // [15:0] piece_index, [16] piece_done, [27:17] received_blocks,
    // [38:28] total_blocks, [46:39] holder_count, [47] zero
    input  logic [rfps_pkg::IN_DATA_BITS-1:0]   s_tdata,
    input  logic                                s_tlast,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // [15:0] chosen_index
    output logic [rfps_pkg::OUT_DATA_BITS-1:0]  m_tdata,
    // [0] found, [1] chose_partial
    output logic [rfps_pkg::OUT_USER_BITS-1:0]  m_tuser
);

    logic            push;
    logic            pop;
    logic            queue_full;
    logic            queue_empty;
    rfps_pkg::item_t push_item;
    rfps_pkg::item_t pop_item;

    rfps_front u_front (
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .queue_full (queue_full),
        .push       (push),
        .item       (push_item)
    );

    rfps_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .full      (queue_full),
        .pop       (pop),
        .pop_item  (pop_item),
        .empty     (queue_empty)
    );

    rfps_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .queue_empty (queue_empty),
        .queue_item  (pop_item),
        .pop         (pop),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

endmodule

// ===== sv/rfps_front.sv =====
// Front end: accepts piece records, saturates counts and classifies them.
module rfps_front (
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // [15:0] piece_index, [16] piece_done, [27:17] received_blocks,
    // [38:28] total_blocks, [46:39] holder_count, [47] zero
    input  logic [rfps_pkg::IN_DATA_BITS-1:0] s_tdata,
    input  logic                             s_tlast,
    input  logic                             queue_full,
    output logic                             push,
    output rfps_pkg::item_t                  item
);

    logic                           done;
    logic [rfps_pkg::BLOCK_BITS-1:0] recv_raw;
    logic [rfps_pkg::BLOCK_BITS-1:0] total_raw;
    logic [rfps_pkg::HOLD_BITS-1:0]  hold_raw;
    logic [rfps_pkg::BLOCK_BITS-1:0] recv_sat;
    logic [rfps_pkg::BLOCK_BITS-1:0] total_sat;

    assign done      = s_tdata[16];
    assign recv_raw  = s_tdata[27:17];
    assign total_raw = s_tdata[38:28];
    assign hold_raw  = s_tdata[46:39];

    assign s_tready = !queue_full;
    assign push     = s_tvalid && !queue_full;

    always_comb
    begin
        total_sat = (total_raw > rfps_pkg::MAX_BLOCKS) ? rfps_pkg::MAX_BLOCKS : total_raw;
        recv_sat  = (recv_raw > rfps_pkg::MAX_BLOCKS) ? rfps_pkg::MAX_BLOCKS : recv_raw;
        // limit received to total
        if (recv_sat > total_sat)
        begin
            recv_sat = total_sat;
        end
        item.index    = s_tdata[rfps_pkg::INDEX_BITS-1:0];
        item.pending  = !done;
        item.partial  = !done && (recv_sat != '0);
        item.received = recv_sat;
        item.total    = total_sat;
        item.holders  = (hold_raw > rfps_pkg::MAX_HOLDERS) ? rfps_pkg::MAX_HOLDERS : hold_raw;
        item.last     = s_tlast;
    end

endmodule

// ===== sv/rfps_queue.sv =====
// Short queue between the front end and the scoring back end.
module rfps_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  rfps_pkg::item_t push_item,
    output logic            full,
    input  logic            pop,
    output rfps_pkg::item_t pop_item,
    output logic            empty
);

    rfps_pkg::item_t                 entry_reg [rfps_pkg::QUEUE_DEPTH];
    logic [rfps_pkg::QPTR_BITS-1:0]  wr_ptr_reg;
    logic [rfps_pkg::QPTR_BITS-1:0]  wr_ptr_next;
    logic [rfps_pkg::QPTR_BITS-1:0]  rd_ptr_reg;
    logic [rfps_pkg::QPTR_BITS-1:0]  rd_ptr_next;
    logic [rfps_pkg::QCNT_BITS-1:0]  count_reg;
    logic [rfps_pkg::QCNT_BITS-1:0]  count_next;

    assign full     = (count_reg == rfps_pkg::QCNT_BITS'(rfps_pkg::QUEUE_DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_item = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// ===== sv/rfps_back.sv =====
// Back end: scores partial pieces with a shared divider, tracks the best
// and rarest picks, and emits the choice at the end of a scan.
module rfps_back (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                queue_empty,
    input  rfps_pkg::item_t                     queue_item,
    output logic                                pop,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // [15:0] chosen_index
    output logic [rfps_pkg::OUT_DATA_BITS-1:0]  m_tdata,
    // [0] found, [1] chose_partial
    output logic [rfps_pkg::OUT_USER_BITS-1:0]  m_tuser
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_DIV   = 3'd1;
    localparam logic [2:0] S_SCORE = 3'd2;
    localparam logic [2:0] S_UPD   = 3'd3;

    localparam logic [3:0] LAST_STEP = 4'(rfps_pkg::QUO_BITS - 1);

    logic [2:0]                        state_reg;
    logic [2:0]                        state_next;
    rfps_pkg::item_t                   cur_reg;

    logic [rfps_pkg::BLOCK_BITS-1:0]   rem_reg;
    logic [rfps_pkg::QUO_BITS-1:0]     quo_reg;
    logic [rfps_pkg::QUO_BITS-1:0]     dvd_reg;
    logic [rfps_pkg::BLOCK_BITS-1:0]   dsr_reg;
    logic [3:0]                        cnt_reg;
    logic                              phase_reg;
    logic [rfps_pkg::QUO_BITS-1:0]     permille_reg;
    logic [rfps_pkg::SCORE_BITS-1:0]   score_reg;

    logic [rfps_pkg::SCORE_BITS-1:0]   best_score_reg;
    logic [rfps_pkg::INDEX_BITS-1:0]   best_index_reg;
    logic                              have_partial_reg;
    logic [rfps_pkg::HOLD_BITS-1:0]    fewest_reg;
    logic [rfps_pkg::INDEX_BITS-1:0]   rarest_index_reg;
    logic                              have_pending_reg;

    logic                              out_valid_reg;
    logic [rfps_pkg::OUT_DATA_BITS-1:0] out_data_reg;
    logic [rfps_pkg::OUT_USER_BITS-1:0] out_user_reg;

    logic [rfps_pkg::DVD_BITS-1:0]     dividend;
    logic [rfps_pkg::BLOCK_BITS:0]     rem_shift;
    logic                              rem_ge;
    logic [rfps_pkg::BLOCK_BITS:0]     rem_diff;
    logic [rfps_pkg::QUO_BITS-1:0]     quo_step;
    logic [rfps_pkg::SCORE_BITS-1:0]   rarity;
    logic                              take_partial;
    logic                              take_rarest;
    logic                              have_partial_upd;
    logic                              have_pending_upd;
    logic [rfps_pkg::INDEX_BITS-1:0]   best_index_upd;
    logic [rfps_pkg::INDEX_BITS-1:0]   rarest_index_upd;
    logic                              out_blocked;
    logic                              upd_fire;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

    // received * 1000 always fits in twice the quotient width
    assign dividend = rfps_pkg::DVD_BITS'(queue_item.received) *
                      rfps_pkg::DVD_BITS'(rfps_pkg::PER_MILLE);

    // one restoring division step; the quotient is known to stay below 1024
    assign rem_shift = {rem_reg, dvd_reg[rfps_pkg::QUO_BITS-1]};
    assign rem_ge    = rem_shift >= {1'b0, dsr_reg};
    assign rem_diff  = rem_shift - {1'b0, dsr_reg};
    assign quo_step  = {quo_reg[rfps_pkg::QUO_BITS-2:0], rem_ge};

    assign rarity = (cur_reg.holders == '0) ? rfps_pkg::NO_HOLDER_RARITY
                                            : rfps_pkg::SCORE_BITS'(quo_reg);

    assign pop = (state_reg == S_IDLE) && !queue_empty;

    assign out_blocked = cur_reg.last && out_valid_reg && !m_tready;
    assign upd_fire    = (state_reg == S_UPD) && !out_blocked;

    always_comb
    begin
        take_partial = cur_reg.partial && (!have_partial_reg || score_reg > best_score_reg);
        take_rarest  = cur_reg.pending &&
                       (!have_pending_reg || cur_reg.holders < fewest_reg);
        have_partial_upd = have_partial_reg || take_partial;
        have_pending_upd = have_pending_reg || take_rarest;
        best_index_upd   = take_partial ? cur_reg.index : best_index_reg;
        rarest_index_upd = take_rarest ? cur_reg.index : rarest_index_reg;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (!queue_empty)
                begin
                    state_next = queue_item.partial ? S_DIV : S_UPD;
                end
            end
            S_DIV:
            begin
                if (cnt_reg == LAST_STEP && phase_reg)
                begin
                    state_next = S_SCORE;
                end
            end
            S_SCORE:
            begin
                state_next = S_UPD;
            end
            S_UPD:
            begin
                if (!out_blocked)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            best_score_reg   <= '0;
            best_index_reg   <= '0;
            have_partial_reg <= 1'b0;
            fewest_reg       <= '0;
            rarest_index_reg <= '0;
            have_pending_reg <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (upd_fire && cur_reg.last)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (upd_fire)
            begin
                if (cur_reg.last)
                begin
                    // emit the choice and start a fresh scan
                    best_score_reg   <= '0;
                    best_index_reg   <= '0;
                    have_partial_reg <= 1'b0;
                    fewest_reg       <= '0;
                    rarest_index_reg <= '0;
                    have_pending_reg <= 1'b0;
                end
                else
                begin
                    if (take_partial)
                    begin
                        best_score_reg <= score_reg;
                    end
                    if (take_rarest)
                    begin
                        fewest_reg <= cur_reg.holders;
                    end
                    best_index_reg   <= best_index_upd;
                    rarest_index_reg <= rarest_index_upd;
                    have_partial_reg <= have_partial_upd;
                    have_pending_reg <= have_pending_upd;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            cur_reg   <= queue_item;
            rem_reg   <= rfps_pkg::BLOCK_BITS'(dividend[rfps_pkg::DVD_BITS-1:rfps_pkg::QUO_BITS]);
            dvd_reg   <= dividend[rfps_pkg::QUO_BITS-1:0];
            dsr_reg   <= queue_item.total;
            quo_reg   <= '0;
            cnt_reg   <= '0;
            phase_reg <= 1'b0;
        end
        else if (state_reg == S_DIV)
        begin
            if (cnt_reg == LAST_STEP && !phase_reg)
            begin
                // hold per mille, then divide 1000 by the holder count
                permille_reg <= quo_step;
                rem_reg      <= '0;
                dvd_reg      <= rfps_pkg::PER_MILLE;
                dsr_reg      <= rfps_pkg::BLOCK_BITS'(cur_reg.holders);
                quo_reg      <= '0;
                cnt_reg      <= '0;
                phase_reg    <= 1'b1;
            end
            else
            begin
                rem_reg <= rem_ge ? rem_diff[rfps_pkg::BLOCK_BITS-1:0]
                                  : rem_shift[rfps_pkg::BLOCK_BITS-1:0];
                dvd_reg <= {dvd_reg[rfps_pkg::QUO_BITS-2:0], 1'b0};
                quo_reg <= quo_step;
                cnt_reg <= cnt_reg + 1'b1;
            end
        end
        if (state_reg == S_SCORE)
        begin
            score_reg <= rfps_pkg::SCORE_BITS'(permille_reg) *
                         rfps_pkg::SCORE_BITS'(rfps_pkg::SCORE_SCALE) + rarity;
        end
        if (upd_fire && cur_reg.last)
        begin
            if (have_partial_upd)
            begin
                out_data_reg <= best_index_upd;
                out_user_reg <= 2'b11;
            end
            else if (have_pending_upd)
            begin
                out_data_reg <= rarest_index_upd;
                out_user_reg <= 2'b01;
            end
            else
            begin
                out_data_reg <= '0;
                out_user_reg <= 2'b00;
            end
        end
    end

endmodule
